FILE: rtl/float_to_pcm_sample_packer_assert.svh
// Assertion macros for the float to PCM sample packer checker.
`ifndef FLOAT_TO_PCM_SAMPLE_PACKER_ASSERT_SVH
`define FLOAT_TO_PCM_SAMPLE_PACKER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define FPCM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("fpcm check failed");

// Next-cycle implication.
`define FPCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("fpcm check failed");

`endif

FILE: rtl/fpcm_pkg.sv
// ----------------------------------------------------------------------------
// fpcm_pkg
// Shared types and constants for the float to PCM sample packer.
// ----------------------------------------------------------------------------
`default_nettype none
package fpcm_pkg;

	localparam logic [2:0] FMT_F32    = 3'd0;
	localparam logic [2:0] FMT_S32LE  = 3'd1;
	localparam logic [2:0] FMT_S32BE  = 3'd2;
	localparam logic [2:0] FMT_S24LE  = 3'd3;
	localparam logic [2:0] FMT_S24BE  = 3'd4;
	localparam logic [2:0] FMT_S16LE  = 3'd5;
	localparam logic [2:0] FMT_S16BE  = 3'd6;
	localparam logic [2:0] FMT_RESET  = FMT_S32LE;

	localparam logic [31:0] K32 = 32'h7FFF_FFFF;
	localparam logic [31:0] K24 = 32'h007F_FFFF;
	localparam logic [31:0] K16 = 32'h0000_7FFF;

	localparam logic [30:0] ONE_ABS = 31'h3F80_0000;
	localparam logic [30:0] INF_ABS = 31'h7F80_0000;

	// Kind of value after classification
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_SAT  = 2'd1,
		CLS_MUL  = 2'd2
	} cls_t;

	// Pipeline side-band carried with each sample
	typedef struct packed {
		logic [2:0]  fmt;
		logic        last;
		logic        neg;
		logic [31:0] raw;
	} side_t;

endpackage
`default_nettype wire

FILE: rtl/float_to_pcm_sample_packer.sv
// ----------------------------------------------------------------------------
// float_to_pcm_sample_packer
// Float32 audio sample to packed PCM word, format set by a register.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s_axis   in   tdata: sample_bits[31:0]; tlast: last_in
// m_axis   out  tdata: packed_bytes[31:0], byte_count[34:32]; tlast: last_out
// cfg      in   cfg_wr_en / cfg_wr_data: output_format
//
// One sample per cycle unless m_axis stalls (three scaling stages, one
// packing/output stage). The 24x32 multiply sets stage depth.
// Reset clears valid bits and sets format to s32le.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module float_to_pcm_sample_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // sample_bits[31:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // packed_bytes[31:0], byte_count[34:32]
	output logic             m_axis_tlast
);
	import fpcm_pkg::*;

	logic [2:0] fmt_q;
	logic       en;
	logic       sc_valid;
	logic [31:0] v;
	side_t      side_in, side_s3;

	// Format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= FMT_RESET;
		else if (cfg_wr_en) fmt_q <= cfg_wr_data;
	end

	// Whole pipe advances when output slot is free or empty
	assign en = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;

	assign side_in = '{fmt: fmt_q, last: s_axis_tlast, neg: s_axis_tdata[31],
		raw: s_axis_tdata};

	fpcm_scale u_scale (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid), .bits(s_axis_tdata), .side_in(side_in),
		.out_valid(sc_valid), .value(v), .side_out(side_s3)
	);

	// Byte layout
	logic [31:0] packed_w;
	logic [2:0]  cnt;
	always_comb begin
		case (side_s3.fmt)
			FMT_S32LE: begin packed_w = v; cnt = 3'd4; end
			FMT_S32BE: begin packed_w = {v[7:0], v[15:8], v[23:16], v[31:24]}; cnt = 3'd4; end
			FMT_S24LE: begin packed_w = {8'd0, v[23:0]}; cnt = 3'd3; end
			FMT_S24BE: begin packed_w = {8'd0, v[7:0], v[15:8], v[23:16]}; cnt = 3'd3; end
			FMT_S16LE: begin packed_w = {16'd0, v[15:0]}; cnt = 3'd2; end
			FMT_S16BE: begin packed_w = {16'd0, v[7:0], v[15:8]}; cnt = 3'd2; end
			default:   begin packed_w = side_s3.raw; cnt = 3'd4; end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= sc_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {5'd0, cnt, packed_w};
			m_axis_tlast <= side_s3.last;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fpcm_scale.sv
// ----------------------------------------------------------------------------
// fpcm_scale
// Three-stage exact clamp(x)*K with truncation; stall by a common enable.
// ----------------------------------------------------------------------------
`default_nettype none
module fpcm_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [31:0]          bits,
	input  wire fpcm_pkg::side_t      side_in,
	output logic                      out_valid,
	output logic [31:0]               value,
	output fpcm_pkg::side_t           side_out
);
	import fpcm_pkg::*;

	// Stage 1: classify, pick K, build mantissa and shift
	logic [30:0] absb;
	logic [7:0]  ex;
	logic [23:0] man;
	logic [7:0]  sh;
	logic [31:0] kval;
	cls_t        cls;

	always_comb begin
		absb = bits[30:0];
		ex   = (absb[30:23] == 8'd0) ? 8'd1 : absb[30:23];
		man  = {(absb[30:23] != 8'd0), absb[22:0]};
		sh   = 8'd150 - ex;
		case (side_in.fmt)
			FMT_S32LE, FMT_S32BE: kval = K32;
			FMT_S24LE, FMT_S24BE: kval = K24;
			default:              kval = K16;
		endcase
		if (absb > INF_ABS)       cls = CLS_ZERO;
		else if (absb >= ONE_ABS) cls = CLS_SAT;
		else                      cls = CLS_MUL;
	end

	logic        v_s1, v_s2;
	logic [23:0] man_s1;
	logic [31:0] k_s1;
	logic [7:0]  sh_s1, sh_s2;
	cls_t        cls_s1, cls_s2;
	side_t       side_s1, side_s2;
	logic [55:0] prod_s2;
	logic [31:0] k_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	// Stage 2: 24 x 32 product
	always_ff @(posedge clk) begin
		if (en) begin
			man_s1  <= man;
			k_s1    <= kval;
			sh_s1   <= sh;
			cls_s1  <= cls;
			side_s1 <= side_in;
			prod_s2 <= {32'd0, man_s1} * {24'd0, k_s1};
			k_s2    <= k_s1;
			sh_s2   <= sh_s1;
			cls_s2  <= cls_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: shift, select and negate
	logic [55:0] shifted;
	logic [31:0] mag;

	always_comb begin
		shifted = (sh_s2 >= 8'd56) ? 56'd0 : (prod_s2 >> sh_s2[5:0]);
		case (cls_s2)
			CLS_SAT: mag = k_s2;
			CLS_MUL: mag = shifted[31:0];
			default: mag = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value    <= side_s2.neg ? (32'd0 - mag) : mag;
			side_out <= side_s2;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fpcm_checker.sv
// ----------------------------------------------------------------------------
// fpcm_checker
// Port-level checks of the float to PCM sample packer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "float_to_pcm_sample_packer_assert.svh"
module fpcm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);
	logic [2:0] cnt_w;
	logic       cnt_ok_w;
	logic       stall_w;

	assign cnt_w    = m_axis_tdata[34:32];
	assign cnt_ok_w = (cnt_w == 3'd2) || (cnt_w == 3'd3) || (cnt_w == 3'd4);
	assign stall_w  = m_axis_tvalid && !m_axis_tready;

	// Byte count 2..4 on every valid beat
	`FPCM_ASSERT_IMPL(a_cnt, clk, arst_n, m_axis_tvalid, cnt_ok_w)
	// Upper pad bits zero
	`FPCM_ASSERT_IMPL(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[39:35] == 5'd0)
	// Input ready follows output slot
	`FPCM_ASSERT_IMPL(a_rdy, clk, arst_n, 1'b1, s_axis_tready == (m_axis_tready || !m_axis_tvalid))
	// Stalled beat holds
	`FPCM_ASSERT_NEXT(a_hold, clk, arst_n, stall_w, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind float_to_pcm_sample_packer fpcm_checker u_fpcm_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream check of the float to PCM sample packer against a local predictor.
// Directed samples (zeros, one, infinities, NaNs, subnormals, saturation) run
// under every output format, then random beats under changing formats and
// idle patterns on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import fpcm_pkg::*;

	localparam int N_DIRECTED = 16;
	localparam int N_RANDOM   = 306;

	// Expected output beat
	typedef struct {
		logic [31:0] packed_word;
		logic [2:0]  nbytes;
		logic        last;
	} pcm_beat_t;

	// Directed row; has_exp set where the result is obvious
	typedef struct {
		logic [31:0] sample;
		logic        last;
		bit          has_exp;
		logic [31:0] exp_s32le;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic [2:0]  fmt_shadow = FMT_RESET;
	pcm_beat_t   pending_beats[$];
	int          mismatches = 0;
	int          beats_seen = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 1'b0;
	stim_row_t   directed[N_DIRECTED];

	float_to_pcm_sample_packer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // sample_bits[31:0]
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // packed_bytes[31:0], byte_count[34:32]
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Clamp, exact scale by k, truncate toward zero; two's complement out
	function automatic logic [31:0] scale_to_int(logic [31:0] bits, logic [31:0] k);
		logic [30:0] mag_bits;
		logic [7:0]  ex;
		logic [63:0] man;
		logic [63:0] mag;
		int          sh;
		mag_bits = bits[30:0];
		if (mag_bits > INF_ABS)
			return 32'd0;
		if (mag_bits >= ONE_ABS) begin
			mag = {32'd0, k};
		end else begin
			ex = mag_bits[30:23];
			man = {41'd0, mag_bits[22:0]};
			if (ex == 8'd0)
				ex = 8'd1;
			else
				man[23] = 1'b1;
			sh = 150 - ex;
			mag = (sh >= 64) ? 64'd0 : ((man * {32'd0, k}) >> sh);
		end
		return bits[31] ? (32'd0 - mag[31:0]) : mag[31:0];
	endfunction

	function automatic pcm_beat_t pack_sample(logic [2:0] fmt, logic [31:0] bits,
			logic last);
		pcm_beat_t b;
		logic [31:0] v;
		b.last = last;
		case (fmt)
			FMT_S32LE: begin
				b.packed_word = scale_to_int(bits, K32);
				b.nbytes = 3'd4;
			end
			FMT_S32BE: begin
				v = scale_to_int(bits, K32);
				b.packed_word = {v[7:0], v[15:8], v[23:16], v[31:24]};
				b.nbytes = 3'd4;
			end
			FMT_S24LE: begin
				v = scale_to_int(bits, K24);
				b.packed_word = {8'd0, v[23:0]};
				b.nbytes = 3'd3;
			end
			FMT_S24BE: begin
				v = scale_to_int(bits, K24);
				b.packed_word = {8'd0, v[7:0], v[15:8], v[23:16]};
				b.nbytes = 3'd3;
			end
			FMT_S16LE: begin
				v = scale_to_int(bits, K16);
				b.packed_word = {16'd0, v[15:0]};
				b.nbytes = 3'd2;
			end
			FMT_S16BE: begin
				v = scale_to_int(bits, K16);
				b.packed_word = {16'd0, v[7:0], v[15:8]};
				b.nbytes = 3'd2;
			end
			default: begin
				b.packed_word = bits;
				b.nbytes = 3'd4;
			end
		endcase
		return b;
	endfunction

	// Receiver: stall pattern, output check
	always @(posedge clk) begin
		pcm_beat_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected beat: data %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				e = pending_beats.pop_front();
				if (m_axis_tdata[31:0] !== e.packed_word || m_axis_tdata[34:32] !== e.nbytes
						|| m_axis_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: exp %h/%0d/%b got %h/%0d/%b",
							e.packed_word, e.nbytes, e.last,
							m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
				end
			end
		end
		if (!arst_n || hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted in its own process
	task automatic hold_receiver(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	task automatic write_format(logic [2:0] fmt);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= fmt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fmt_shadow = fmt;
	endtask

	task automatic drain_outputs();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Offer one sample, random idle before it, hold until accepted
	task automatic send_sample(logic [31:0] bits, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= bits;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_beats.push_back(pack_sample(fmt_shadow, bits, last));
	endtask

	function automatic logic [31:0] random_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(5))
			0: return r;
			1: return {r[31], 8'd0, r[22:0]};
			2: return {r[31], 8'hFF, r[22:0]};
			default: return {r[31], 8'($urandom_range(100, 127)), r[22:0]};
		endcase
	endfunction

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		pcm_beat_t e;
		logic [2:0] fmt;
		directed[0]  = '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000};
		directed[1]  = '{32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000};
		directed[2]  = '{32'h3F80_0000, 1'b0, 1'b1, 32'h7FFF_FFFF};
		directed[3]  = '{32'hBF80_0000, 1'b1, 1'b1, 32'h8000_0001};
		directed[4]  = '{32'h7F80_0000, 1'b0, 1'b1, 32'h7FFF_FFFF};
		directed[5]  = '{32'hFF80_0000, 1'b0, 1'b1, 32'h8000_0001};
		directed[6]  = '{32'h7FC0_0000, 1'b0, 1'b1, 32'h0000_0000};
		directed[7]  = '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000};
		directed[8]  = '{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000};
		directed[9]  = '{32'h807F_FFFF, 1'b0, 1'b1, 32'h0000_0000};
		directed[10] = '{32'h7F7F_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF};
		directed[11] = '{32'h3F00_0000, 1'b0, 1'b0, 32'h0};
		directed[12] = '{32'hBF7F_FFFF, 1'b0, 1'b0, 32'h0};
		directed[13] = '{32'h3F7F_FFFF, 1'b1, 1'b0, 32'h0};
		directed[14] = '{32'h3000_0001, 1'b0, 1'b0, 32'h0};
		directed[15] = '{32'hC2C8_0000, 1'b1, 1'b1, 32'h8000_0001};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset format, then each format
		for (int f = 0; f <= 8; f++) begin
			if (f > 0)
				write_format((f == 8) ? 3'd7 : 3'(f - 1));
			for (int i = 0; i < N_DIRECTED; i++) begin
				send_sample(directed[i].sample, directed[i].last);
				if (fmt_shadow == FMT_S32LE && directed[i].has_exp) begin
					e = pending_beats.pop_back();
					e.packed_word = directed[i].exp_s32le;
					pending_beats.push_back(e);
				end
			end
			s_axis_tvalid <= 1'b0;
			drain_outputs();
		end

		// Random phases
		for (int p = 0; p < 9; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			fmt = (p == 0) ? FMT_F32 : (p == 1) ? FMT_S16BE : 3'($urandom_range(7));
			write_format(fmt);
			if (p == 4) begin
				fork
					hold_receiver(60);
				join_none
			end
			for (int i = 0; i < N_RANDOM / 9; i++)
				send_sample(random_sample(), 1'($urandom));
			s_axis_tvalid <= 1'b0;
			// sender pause until all results are in
			drain_outputs();
		end

		$display("Covered %0d output beats over all seven formats plus the spare code,",
			beats_seen);
		$display("with saturation, NaN, subnormal and idle/stall patterns on both sides.");
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: float_to_pcm_sample_packer.f
+incdir+rtl
rtl/fpcm_pkg.sv
rtl/fpcm_scale.sv
rtl/float_to_pcm_sample_packer.sv
rtl/fpcm_checker.sv
tb/sv/testbench.sv
